// File: rtl/core/kvrf_pkg.sv
`default_nettype none
package kvrf_pkg;

  typedef logic [3:0] kind_t;

  localparam kind_t KIND_PING              = 4'd0;
  localparam kind_t KIND_CLEAR             = 4'd1;
  localparam kind_t KIND_PUT               = 4'd2;
  localparam kind_t KIND_PUT_IF_ABSENT     = 4'd3;
  localparam kind_t KIND_REPLACE           = 4'd4;
  localparam kind_t KIND_REPLACE_VERSIONED = 4'd5;
  localparam kind_t KIND_GET               = 4'd6;
  localparam kind_t KIND_REMOVE            = 4'd7;
  localparam kind_t KIND_REMOVE_VERSIONED  = 4'd8;
  localparam kind_t KIND_CONTAINS          = 4'd9;
  localparam kind_t KIND_GET_VERSIONED     = 4'd10;
  localparam kind_t KIND_GET_BULK          = 4'd11;

  localparam logic [7:0] HDR_MAGIC   = 8'hA0;
  localparam logic [7:0] HDR_MSG_ID  = 8'h01;
  localparam logic [7:0] HDR_INTEL   = 8'h03;
  localparam logic [7:0] HDR_ZERO    = 8'h00;
  localparam logic [2:0] HDR_LAST    = 3'd6;
  localparam logic [2:0] VER_LAST    = 3'd7;

  localparam int CFG_DATA_W = 31;
  localparam logic REG_PROTOCOL_VERSION = 1'b0;
  localparam logic REG_TOPOLOGY_ID      = 1'b1;

  localparam logic [7:0] PROTOCOL_VERSION_RESET = 8'h0B;

  function automatic logic [7:0] opcode(kind_t k);
    logic [7:0] op;
    case (k)
      KIND_PING:              op = 8'h17;
      KIND_CLEAR:             op = 8'h13;
      KIND_PUT:               op = 8'h01;
      KIND_PUT_IF_ABSENT:     op = 8'h05;
      KIND_REPLACE:           op = 8'h07;
      KIND_REPLACE_VERSIONED: op = 8'h09;
      KIND_GET:               op = 8'h03;
      KIND_REMOVE:            op = 8'h0B;
      KIND_REMOVE_VERSIONED:  op = 8'h0D;
      KIND_CONTAINS:          op = 8'h0F;
      KIND_GET_VERSIONED:     op = 8'h11;
      KIND_GET_BULK:          op = 8'h19;
      default:                op = 8'h00;
    endcase
    return op;
  endfunction

  function automatic logic is_put(kind_t k);
    return (k == KIND_PUT) || (k == KIND_PUT_IF_ABSENT) || (k == KIND_REPLACE) ||
           (k == KIND_REPLACE_VERSIONED);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/kvrf_in_if.sv
`default_nettype none
interface kvrf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         request_kind;
  logic [15:0]        key_length;
  logic [15:0]        value_length;
  logic [7:0]         lifespan;
  logic [7:0]         idle_time;
  logic signed [63:0] entry_version;
  logic [30:0]        entry_count;
  logic [7:0]         data_byte;

  modport source (
    output valid, action, request_kind, key_length, value_length, lifespan,
           idle_time, entry_version, entry_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, action, request_kind, key_length, value_length, lifespan,
           idle_time, entry_version, entry_count, data_byte,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/kvrf_out_if.sv
`default_nettype none
interface kvrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       ends_request;

  modport source (output valid, out_byte, last_of_item, ends_request, input ready);
  modport sink   (input valid, out_byte, last_of_item, ends_request, output ready);
endinterface
`default_nettype wire

// File: rtl/core/kv_request_framer_core.sv
// Request framer: turns request descriptors and key/value data bytes into the
// byte stream of one cache-protocol request.
// Channels: req (sink) carries either a descriptor (action 0) or one data byte
// (action 1); frame (source) carries one output byte per transfer with flags
// last_of_item and ends_request. cfg_en/cfg_index/cfg_data write the protocol
// version (index 0) and the topology id (index 1); write only while idle.
// Throughput: key or value data bytes are taken one per cycle, back to back,
// while frame is ready, each byte showing on frame the cycle after acceptance.
// A descriptor is followed by its header bytes (9 to 13), the length or count
// varint (1 to 5 bytes) and, for an empty key, the trailer; the last key byte
// is followed by its trailer bytes (up to 13).
// Varint and version bytes go one per cycle, while frame is ready, through a
// single shared 64-bit shift register driven by the sequencer; the fixed header
// bytes come from a table; req is not ready while the sequencer walks them.
// Reset: idle, no open request, output empty, protocol version 11, topology 0.
// Stall: an output register decouples frame; while frame is not ready the
// held byte stays and the sequencer and req wait.
`default_nettype none
module kv_request_framer_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  kvrf_in_if.sink                       req,
  kvrf_out_if.source                    frame,
  input  logic                          cfg_en,
  input  logic                          cfg_index,
  input  logic [kvrf_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_WAIT, S_HDR, S_TOPO, S_HDR_END, S_VAR, S_LIFE, S_IDLE, S_VER
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_VALUE} phase_t;
  typedef enum logic [1:0] {V_KEYLEN, V_COUNT, V_VALLEN} var_sel_t;

  state_t                  st;
  phase_t                  phase;
  var_sel_t                var_sel;
  kvrf_pkg::kind_t         kind_held;
  logic [LENGTH_BITS-1:0]  key_left;
  logic [LENGTH_BITS-1:0]  value_left;
  logic [LENGTH_BITS-1:0]  value_length_held;
  logic [7:0]              lifespan_held;
  logic [7:0]              idle_held;
  logic [63:0]             version_held;
  logic [30:0]             count_held;
  logic [63:0]             shreg;
  logic [2:0]              cnt;
  logic [7:0]              protocol_version;
  logic [30:0]             topology_id;
  logic                    o_valid;
  logic [7:0]              o_byte;
  logic                    o_last;
  logic                    o_end;

  logic                    out_free;
  logic [7:0]              vi_byte;
  logic                    vi_done;
  logic [7:0]              hdr_byte;
  state_t                  kd_state;
  logic                    kd_final;

  assign out_free  = !o_valid || frame.ready;
  assign req.ready = (st == S_WAIT) && out_free;

  assign frame.valid        = o_valid;
  assign frame.out_byte     = o_byte;
  assign frame.last_of_item = o_last;
  assign frame.ends_request = o_end;

  assign vi_done = (shreg[63:7] == 57'd0);
  assign vi_byte = {!vi_done, shreg[6:0]};

  always_comb begin
    case (cnt)
      3'd0:    hdr_byte = kvrf_pkg::HDR_MAGIC;
      3'd1:    hdr_byte = kvrf_pkg::HDR_MSG_ID;
      3'd2:    hdr_byte = protocol_version;
      3'd3:    hdr_byte = kvrf_pkg::opcode(kind_held);
      3'd4:    hdr_byte = kvrf_pkg::HDR_ZERO;
      3'd5:    hdr_byte = kvrf_pkg::HDR_ZERO;
      default: hdr_byte = kvrf_pkg::HDR_INTEL;
    endcase
  end

  // what follows the last key byte
  always_comb begin
    if (kvrf_pkg::is_put(kind_held)) begin
      kd_state = S_LIFE;
      kd_final = 1'b0;
    end else if (kind_held == kvrf_pkg::KIND_REMOVE_VERSIONED) begin
      kd_state = S_VER;
      kd_final = 1'b0;
    end else begin
      kd_state = S_WAIT;
      kd_final = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st               <= S_WAIT;
      phase            <= PH_IDLE;
      var_sel          <= V_KEYLEN;
      kind_held        <= kvrf_pkg::KIND_PING;
      key_left         <= '0;
      value_left       <= '0;
      cnt              <= 3'd0;
      o_valid          <= 1'b0;
      protocol_version <= kvrf_pkg::PROTOCOL_VERSION_RESET;
      topology_id      <= 31'd0;
    end else begin
      if (frame.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg_en) begin
        unique case (cfg_index)
          kvrf_pkg::REG_PROTOCOL_VERSION: protocol_version <= cfg_data[7:0];
          kvrf_pkg::REG_TOPOLOGY_ID:      topology_id      <= cfg_data;
          default: ;
        endcase
      end
      unique case (st)
        S_WAIT: begin
          if (req.valid && req.ready) begin
            if (!req.action) begin
              phase <= PH_IDLE;
              if (req.request_kind <= kvrf_pkg::KIND_GET_BULK) begin
                kind_held         <= req.request_kind;
                key_left          <= LENGTH_BITS'(req.key_length);
                value_left        <= '0;
                value_length_held <= LENGTH_BITS'(req.value_length);
                lifespan_held     <= req.lifespan;
                idle_held         <= req.idle_time;
                version_held      <= req.entry_version;
                count_held        <= req.entry_count;
                cnt               <= 3'd0;
                st                <= S_HDR;
              end
            end else begin
              unique case (phase)
                PH_KEY: begin
                  o_valid  <= 1'b1;
                  o_byte   <= req.data_byte;
                  key_left <= key_left - LENGTH_BITS'(1);
                  if (key_left == LENGTH_BITS'(1)) begin
                    o_last <= kd_final;
                    o_end  <= kd_final;
                    phase  <= PH_IDLE;
                    st     <= kd_state;
                    shreg  <= version_held;
                    cnt    <= 3'd0;
                  end else begin
                    o_last <= 1'b1;
                    o_end  <= 1'b0;
                  end
                end
                PH_VALUE: begin
                  o_valid    <= 1'b1;
                  o_byte     <= req.data_byte;
                  o_last     <= 1'b1;
                  o_end      <= (value_left == LENGTH_BITS'(1));
                  value_left <= value_left - LENGTH_BITS'(1);
                  if (value_left == LENGTH_BITS'(1)) begin
                    phase <= PH_IDLE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= hdr_byte;
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            cnt     <= cnt + 3'd1;
            if (cnt == kvrf_pkg::HDR_LAST) begin
              shreg <= 64'(topology_id);
              st    <= S_TOPO;
            end
          end
        end
        S_TOPO: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= vi_byte;
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            shreg   <= shreg >> 7;
            if (vi_done) begin
              st <= S_HDR_END;
            end
          end
        end
        S_HDR_END: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= kvrf_pkg::HDR_ZERO;
            if (kind_held <= kvrf_pkg::KIND_CLEAR) begin
              o_last <= 1'b1;
              o_end  <= 1'b1;
              st     <= S_WAIT;
            end else if (kind_held == kvrf_pkg::KIND_GET_BULK) begin
              o_last  <= 1'b0;
              o_end   <= 1'b0;
              shreg   <= 64'(count_held);
              var_sel <= V_COUNT;
              st      <= S_VAR;
            end else begin
              o_last  <= 1'b0;
              o_end   <= 1'b0;
              shreg   <= 64'(key_left);
              var_sel <= V_KEYLEN;
              st      <= S_VAR;
            end
          end
        end
        S_VAR: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= vi_byte;
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            shreg   <= shreg >> 7;
            if (vi_done) begin
              unique case (var_sel)
                V_COUNT: begin
                  o_last <= 1'b1;
                  o_end  <= 1'b1;
                  st     <= S_WAIT;
                end
                V_KEYLEN: begin
                  if (key_left == '0) begin
                    o_last <= kd_final;
                    o_end  <= kd_final;
                    st     <= kd_state;
                    shreg  <= version_held;
                    cnt    <= 3'd0;
                  end else begin
                    o_last <= 1'b1;
                    phase  <= PH_KEY;
                    st     <= S_WAIT;
                  end
                end
                default: begin
                  value_left <= value_length_held;
                  o_last     <= 1'b1;
                  o_end      <= (value_length_held == '0);
                  if (value_length_held != '0) begin
                    phase <= PH_VALUE;
                  end
                  st <= S_WAIT;
                end
              endcase
            end
          end
        end
        S_LIFE: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= lifespan_held;
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            st      <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= idle_held;
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            if (kind_held == kvrf_pkg::KIND_REPLACE_VERSIONED) begin
              shreg <= version_held;
              cnt   <= 3'd0;
              st    <= S_VER;
            end else begin
              shreg   <= 64'(value_length_held);
              var_sel <= V_VALLEN;
              st      <= S_VAR;
            end
          end
        end
        S_VER: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_byte  <= shreg[63:56];
            o_last  <= 1'b0;
            o_end   <= 1'b0;
            shreg   <= shreg << 8;
            cnt     <= cnt + 3'd1;
            if (cnt == kvrf_pkg::VER_LAST) begin
              if (kind_held == kvrf_pkg::KIND_REMOVE_VERSIONED) begin
                o_last <= 1'b1;
                o_end  <= 1'b1;
                st     <= S_WAIT;
              end else begin
                shreg   <= 64'(value_length_held);
                var_sel <= V_VALLEN;
                st      <= S_VAR;
              end
            end
          end
        end
        default: st <= S_WAIT;
      endcase
    end
  end

`ifndef SYNTH
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.ends_request |-> frame.last_of_item)
    else $error("ends_request without last_of_item");

  a_value_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_VALUE |-> value_left != '0)
    else $error("value phase with no bytes left");

  a_key_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_KEY |-> key_left != '0)
    else $error("key phase with no bytes left");

  a_phase_only_waiting: assert property (@(posedge clk) disable iff (rst)
    st != S_WAIT |-> phase == PH_IDLE)
    else $error("open data phase while sequencer busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !frame.valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
